// ===== hdl/eqz_pkg.sv =====
// ----------------------------------------------------------------------------
// eqz_pkg
// Shared types, constants and saturation helpers of the widely linear
// NLMS equalizer.
// ----------------------------------------------------------------------------
package eqz_pkg;

	// NUM_TAPS must be a power of two: the sample store wraps its pointer.
	localparam int NUM_TAPS    = 128;
	localparam int REF_TAP     = 32;
	localparam int SAMPLE_BITS = 16;
	localparam int TAP_BITS    = 24;
	localparam int SAMPLE_FRAC = SAMPLE_BITS - 6;
	localparam int TAP_FRAC    = TAP_BITS - 3;
	localparam int STEP_FRAC   = 30;

	localparam int TAP_AW  = $clog2(NUM_TAPS);
	localparam int CNT_W   = TAP_AW + 1;
	localparam bit REF_ON  = (REF_TAP < NUM_TAPS);
	localparam logic [TAP_AW-1:0] REF_IDX = TAP_AW'(REF_TAP % NUM_TAPS);

	// dot product accumulator: 2*NUM_TAPS products of tap by sample
	localparam int ACC_W  = SAMPLE_BITS + TAP_BITS + TAP_AW + 1;
	// window energy: 2*NUM_TAPS squares
	localparam int EN_W   = 2 * (SAMPLE_BITS - 1) + TAP_AW + 2;
	localparam int DEN_W  = EN_W + 1;
	localparam int ERR_W  = SAMPLE_BITS + 1;
	localparam int NUM_W  = ERR_W - 1 + STEP_FRAC;
	localparam int DIV_CW = $clog2(NUM_W + 1);
	localparam int STEP_W = 41;
	localparam logic [NUM_W-1:0] STEP_LIMIT = NUM_W'(64'd1 << 39);
	localparam int MUL_W  = STEP_W + SAMPLE_BITS;
	localparam int DA_SH  = STEP_FRAC - TAP_FRAC;
	localparam int UPD_W  = MUL_W - DA_SH + 1;
	localparam int YS_W   = ACC_W - TAP_FRAC;

	localparam logic [ACC_W-1:0] Y_RND   = ACC_W'(64'd1 << (TAP_FRAC - 1));
	localparam logic [MUL_W-1:0] UPD_RND = MUL_W'(64'd1 << (DA_SH - 1));

	typedef logic signed [SAMPLE_BITS-1:0] sample_t;
	typedef logic signed [TAP_BITS-1:0]    tap_t;
	typedef logic [TAP_AW-1:0]             tap_idx_t;

	localparam tap_t    TAP_ONE = TAP_BITS'(64'd1 << TAP_FRAC);
	localparam sample_t TARGET  = SAMPLE_BITS'(5 << SAMPLE_FRAC);

	typedef enum logic [1:0] {
		CMD_FILTER = 2'd0,
		CMD_TRAIN  = 2'd1,
		CMD_SKIP   = 2'd2
	} cmd_t;

	function automatic sample_t sat_sample(input logic signed [YS_W-1:0] v);
		logic hi_ones;
		logic hi_zeros;
		hi_ones  = &v[YS_W-1:SAMPLE_BITS-1];
		hi_zeros = ~|v[YS_W-1:SAMPLE_BITS-1];
		if (hi_ones || hi_zeros)
			return v[SAMPLE_BITS-1:0];
		else if (v[YS_W-1])
			return {1'b1, {(SAMPLE_BITS-1){1'b0}}};
		else
			return {1'b0, {(SAMPLE_BITS-1){1'b1}}};
	endfunction

	function automatic tap_t sat_tap(input logic signed [UPD_W-1:0] v);
		logic hi_ones;
		logic hi_zeros;
		hi_ones  = &v[UPD_W-1:TAP_BITS-1];
		hi_zeros = ~|v[UPD_W-1:TAP_BITS-1];
		if (hi_ones || hi_zeros)
			return v[TAP_BITS-1:0];
		else if (v[UPD_W-1])
			return {1'b1, {(TAP_BITS-1){1'b0}}};
		else
			return {1'b0, {(TAP_BITS-1){1'b1}}};
	endfunction

endpackage

// ===== hdl/eqz_line_mem.sv =====
// ----------------------------------------------------------------------------
// eqz_line_mem
// Circular sample store. Reads by position in the window (0 oldest),
// entries not yet written read as zero through a fill count.
// ----------------------------------------------------------------------------
module eqz_line_mem (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  eqz_pkg::sample_t push_re,
	input  eqz_pkg::sample_t push_im,
	input  eqz_pkg::tap_idx_t rd_pos,
	output eqz_pkg::sample_t rd_re,
	output eqz_pkg::sample_t rd_im
);
	import eqz_pkg::*;

	sample_t       mem_re [NUM_TAPS];
	sample_t       mem_im [NUM_TAPS];
	tap_idx_t      wp_q;
	logic [CNT_W-1:0] fill_q;
	tap_idx_t      wr_addr;
	tap_idx_t      rd_addr;
	sample_t       rd_re_q;
	sample_t       rd_im_q;
	logic          rd_vld_q;

	assign wr_addr = wp_q + 1'b1;
	// oldest entry sits just past the newest one
	assign rd_addr = wp_q + 1'b1 + rd_pos;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q     <= '1;
			fill_q   <= '0;
			rd_vld_q <= 1'b0;
		end else begin
			rd_vld_q <= ({1'b0, rd_addr} < fill_q);
			if (push) begin
				wp_q <= wr_addr;
				if (fill_q != CNT_W'(NUM_TAPS))
					fill_q <= fill_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem_re[wr_addr] <= push_re;
			mem_im[wr_addr] <= push_im;
		end
		rd_re_q <= mem_re[rd_addr];
		rd_im_q <= mem_im[rd_addr];
	end

	assign rd_re = rd_vld_q ? rd_re_q : '0;
	assign rd_im = rd_vld_q ? rd_im_q : '0;

endmodule

// ===== hdl/eqz_tap_mem.sv =====
// ----------------------------------------------------------------------------
// eqz_tap_mem
// Tap store for both real tap planes. A valid bit per entry gives the reset
// values: unity at the reference tap of the a plane, zero elsewhere.
// ----------------------------------------------------------------------------
module eqz_tap_mem (
	input  logic              clk,
	input  logic              arst_n,
	input  eqz_pkg::tap_idx_t rd_idx,
	output eqz_pkg::tap_t     rd_a,
	output eqz_pkg::tap_t     rd_b,
	input  logic              wr_en,
	input  eqz_pkg::tap_idx_t wr_idx,
	input  eqz_pkg::tap_t     wr_a,
	input  eqz_pkg::tap_t     wr_b
);
	import eqz_pkg::*;

	tap_t                mem_a [NUM_TAPS];
	tap_t                mem_b [NUM_TAPS];
	logic [NUM_TAPS-1:0] vld_q;
	tap_t                rd_a_q;
	tap_t                rd_b_q;
	logic                rd_vld_q;
	logic                rd_ref_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q    <= '0;
			rd_vld_q <= 1'b0;
			rd_ref_q <= 1'b0;
		end else begin
			rd_vld_q <= vld_q[rd_idx];
			rd_ref_q <= REF_ON && (rd_idx == REF_IDX);
			if (wr_en)
				vld_q[wr_idx] <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_a[wr_idx] <= wr_a;
			mem_b[wr_idx] <= wr_b;
		end
		rd_a_q <= mem_a[rd_idx];
		rd_b_q <= mem_b[rd_idx];
	end

	assign rd_a = rd_vld_q ? rd_a_q : (rd_ref_q ? TAP_ONE : '0);
	assign rd_b = rd_vld_q ? rd_b_q : '0;

endmodule

// ===== hdl/eqz_div.sv =====
// ----------------------------------------------------------------------------
// eqz_div
// Restoring unsigned divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module eqz_div (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      start,
	input  logic [eqz_pkg::NUM_W-1:0] num,
	input  logic [eqz_pkg::DEN_W-1:0] den,
	output logic                      done,
	output logic [eqz_pkg::NUM_W-1:0] quot
);
	import eqz_pkg::*;

	logic              busy_q;
	logic              done_q;
	logic [DIV_CW-1:0] cnt_q;
	logic [DEN_W:0]    rem_q;
	logic [NUM_W-1:0]  nq_q;
	logic [DEN_W-1:0]  den_q;
	logic [DEN_W:0]    trial;
	logic              fits;

	assign trial = {rem_q[DEN_W-1:0], nq_q[NUM_W-1]};
	assign fits  = (trial >= {1'b0, den_q});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= DIV_CW'(NUM_W);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == DIV_CW'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// numerator shifts out as quotient bits shift in
	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			nq_q  <= num;
			den_q <= den;
		end else if (busy_q) begin
			rem_q <= fits ? (trial - {1'b0, den_q}) : trial;
			nq_q  <= {nq_q[NUM_W-2:0], fits};
		end
	end

	assign done = done_q;
	assign quot = nq_q;

endmodule

// ===== hdl/widely_linear_nlms_equalizer_unit.sv =====
// ----------------------------------------------------------------------------
// widely_linear_nlms_equalizer_unit
// Widely linear NLMS equalizer over a 128-entry sample window.
// ----------------------------------------------------------------------------
// Input channel (in_valid/in_ready): cmd, in_re, in_im, target_bit. Every
// beat shifts one sample into the window. Filter beats return one eq_out beat
// on the output channel (out_valid/out_ready); train and skip beats return
// nothing.
// Sequence: one walk over the window reads one tap pair and one sample pair
// per cycle from the tap and sample memories. A filter beat takes one walk
// and then emits its result. A train beat takes one walk, a bit-serial
// division and a second read-modify-write walk. Skip beats only shift
// their sample into the window. in_ready is high only between beats.
// Reset: the window reads as zero and the taps as unity at the reference
// tap, through a fill count and per-tap valid bits; no clearing pass.
// A stalled receiver holds the result in the output register; the next
// beat is accepted meanwhile, and its own result waits for the register.
// ----------------------------------------------------------------------------
module widely_linear_nlms_equalizer_unit (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_ready,
	input  logic [1:0]       cmd,
	input  eqz_pkg::sample_t in_re,
	input  eqz_pkg::sample_t in_im,
	input  logic             target_bit,
	output logic             out_valid,
	input  logic             out_ready,
	output eqz_pkg::sample_t eq_out
);
	import eqz_pkg::*;

	typedef enum logic [5:0] {
		ST_IDLE = 6'b000001,
		ST_DOT  = 6'b000010,
		ST_ERR  = 6'b000100,
		ST_DIV  = 6'b001000,
		ST_UPD  = 6'b010000,
		ST_EMIT = 6'b100000
	} state_t;

	state_t state_q;
	logic [CNT_W-1:0] cnt_q;
	logic     v_s1, v_s2;
	tap_idx_t idx_s1, idx_s2;
	logic     train_q, tgt_q;
	logic     accept, walk, issue, walk_done;

	sample_t  line_re, line_im;
	tap_t     tap_a, tap_b;
	logic signed [STEP_W-1:0] op_a, op_b;
	logic signed [MUL_W-1:0]  m1_s2, m2_s2;
	logic signed [2*SAMPLE_BITS-1:0] er_s2, ei_s2;
	tap_t     ta_s2, tb_s2;

	logic signed [ACC_W-1:0] acc_q;
	logic [EN_W-1:0]  en_q;
	logic signed [ACC_W-1:0] acc_rnd;
	sample_t  y_now, y_q;

	logic signed [ERR_W-1:0] err, err_neg;
	logic [ERR_W-2:0] err_mag;
	logic     neg_q;
	logic [NUM_W-1:0] div_num, div_quot, g_mag;
	logic     div_start, div_done;
	logic signed [STEP_W-1:0] g_q;

	logic signed [MUL_W-1:0] ra, rb;
	logic signed [UPD_W-1:0] da, db;
	tap_t     new_a, new_b;
	logic     tap_we;

	logic     out_valid_q;
	sample_t  eq_out_q;

	assign in_ready  = (state_q == ST_IDLE);
	assign accept    = in_valid && in_ready;
	assign walk      = (state_q == ST_DOT) || (state_q == ST_UPD);
	assign issue     = walk && (cnt_q < CNT_W'(NUM_TAPS));
	assign walk_done = walk && !issue && !v_s1 && !v_s2;

	eqz_line_mem u_line (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (accept),
		.push_re (in_re),
		.push_im (in_im),
		.rd_pos  (cnt_q[TAP_AW-1:0]),
		.rd_re   (line_re),
		.rd_im   (line_im)
	);

	eqz_tap_mem u_taps (
		.clk    (clk),
		.arst_n (arst_n),
		.rd_idx (cnt_q[TAP_AW-1:0]),
		.rd_a   (tap_a),
		.rd_b   (tap_b),
		.wr_en  (tap_we),
		.wr_idx (idx_s2),
		.wr_a   (new_a),
		.wr_b   (new_b)
	);

	// multiplier operand: taps in the dot walk, step size in the update walk
	assign op_a = (state_q == ST_UPD) ? g_q : STEP_W'(tap_a);
	assign op_b = (state_q == ST_UPD) ? g_q : STEP_W'(tap_b);

	always_ff @(posedge clk) begin
		m1_s2 <= op_a * line_re;
		m2_s2 <= op_b * line_im;
		er_s2 <= line_re * line_re;
		ei_s2 <= line_im * line_im;
		ta_s2 <= tap_a;
		tb_s2 <= tap_b;
	end

	// output of the dot product
	assign acc_rnd = acc_q + Y_RND;
	assign y_now   = sat_sample(YS_W'(acc_rnd >>> TAP_FRAC));

	// error and step numerator
	assign err       = (tgt_q ? ERR_W'(TARGET) : -ERR_W'(TARGET)) - ERR_W'(y_q);
	assign err_neg   = -err;
	assign err_mag   = err[ERR_W-1] ? err_neg[ERR_W-2:0] : err[ERR_W-2:0];
	assign div_num   = {err_mag, {STEP_FRAC{1'b0}}};
	assign div_start = (state_q == ST_ERR);
	assign g_mag     = (div_quot > STEP_LIMIT) ? STEP_LIMIT : div_quot;

	eqz_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.num    (div_num),
		.den    ({en_q, 1'b1}),
		.done   (div_done),
		.quot   (div_quot)
	);

	// tap update, rounded half up then saturated
	assign ra     = m1_s2 + UPD_RND;
	assign rb     = m2_s2 + UPD_RND;
	assign da     = UPD_W'(ra >>> DA_SH);
	assign db     = UPD_W'(rb >>> DA_SH);
	assign new_a  = sat_tap(UPD_W'(ta_s2) + da);
	assign new_b  = sat_tap(UPD_W'(tb_s2) + db);
	assign tap_we = (state_q == ST_UPD) && v_s2;

	always_ff @(posedge clk) begin
		if (accept)
			tgt_q <= target_bit;
		if (state_q == ST_DOT && walk_done)
			y_q <= y_now;
		if (div_start)
			neg_q <= err[ERR_W-1];
		if (div_done)
			g_q <= neg_q ? -STEP_W'(g_mag) : STEP_W'(g_mag);
		idx_s1 <= cnt_q[TAP_AW-1:0];
		idx_s2 <= idx_s1;
		if (accept) begin
			acc_q <= '0;
			en_q  <= '0;
		end else if (state_q == ST_DOT && v_s2) begin
			acc_q <= acc_q + ACC_W'(m1_s2) + ACC_W'(m2_s2);
			en_q  <= en_q + EN_W'(er_s2) + EN_W'(ei_s2);
		end
		if (state_q == ST_EMIT && (!out_valid_q || out_ready))
			eq_out_q <= y_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			cnt_q       <= '0;
			v_s1        <= 1'b0;
			v_s2        <= 1'b0;
			train_q     <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			v_s1 <= issue;
			v_s2 <= v_s1;
			if (issue)
				cnt_q <= cnt_q + 1'b1;
			if (state_q == ST_EMIT && (!out_valid_q || out_ready))
				out_valid_q <= 1'b1;
			else if (out_ready)
				out_valid_q <= 1'b0;
			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						cnt_q <= '0;
						case (cmd)
							CMD_FILTER: begin
								train_q <= 1'b0;
								state_q <= ST_DOT;
							end
							CMD_TRAIN: begin
								train_q <= 1'b1;
								state_q <= ST_DOT;
							end
							default: state_q <= ST_IDLE;
						endcase
					end
				end
				ST_DOT: begin
					if (walk_done)
						state_q <= train_q ? ST_ERR : ST_EMIT;
				end
				ST_ERR: state_q <= ST_DIV;
				ST_DIV: begin
					if (div_done) begin
						cnt_q   <= '0;
						state_q <= ST_UPD;
					end
				end
				ST_UPD: begin
					if (walk_done)
						state_q <= ST_IDLE;
				end
				ST_EMIT: begin
					if (!out_valid_q || out_ready)
						state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign out_valid = out_valid_q;
	assign eq_out    = eq_out_q;

`ifndef SYNTHESIS
	a_div_in_div: assert property (@(posedge clk) disable iff (!arst_n)
		div_done |-> state_q == ST_DIV)
		else $error("divider finished outside the divide state");

	a_cnt_range: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CNT_W'(NUM_TAPS))
		else $error("walk counter past the window");

	a_idle_drained: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_IDLE |-> !v_s1 && !v_s2)
		else $error("walk pipeline busy while idle");
`endif

endmodule
